/* rtl/wsfd_pkg.sv */
`default_nettype none
package wsfd_pkg;

    localparam int WORD_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int FNUM_W      = 5;
    localparam int OFFSET_W    = 6;
    localparam int WCOUNT_W    = 5;
    localparam int FRAME_BYTES = 64;
    localparam int MAX_WORDS   = 31;

    // tdata layout of the result channel, lowest bit first
    localparam int M_TDATA_W   = 24;
    localparam int FNUM_LSB    = BYTE_W;
    localparam int OFFSET_LSB  = BYTE_W + FNUM_W;

    localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_byte;
        logic [FNUM_W-1:0]   frame_number;
        logic [OFFSET_W-1:0] byte_offset;
        logic                frame_end;
        logic                run_end;
    } wsfd_result_t;

endpackage
`default_nettype wire

/* rtl/wsfd_seq.sv */
`default_nettype none
module wsfd_seq #(
    parameter int MAX_FRAMES      = 16,
    parameter int WORDS_PER_FRAME = 31
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire  [wsfd_pkg::WORD_W-1:0] in_word,
    input  wire                         in_last,
    output logic                        res_valid,
    input  wire                         res_ready,
    output wsfd_pkg::wsfd_result_t      res
);
    import wsfd_pkg::*;

    localparam int FB_W  = $clog2(MAX_FRAMES + 1);
    localparam int HDR_W = 2 * BYTE_W;
    localparam int CAP   = (WORDS_PER_FRAME < 1) ? 1 :
                           (WORDS_PER_FRAME > MAX_WORDS) ? MAX_WORDS : WORDS_PER_FRAME;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                state_reg, state_next;
    logic [FB_W-1:0]     frames_reg, frames_next;
    logic [WCOUNT_W-1:0] words_reg, words_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [OFFSET_W-1:0] end_off_reg, end_off_next;
    logic [OFFSET_W-1:0] pay_off_reg, pay_off_next;
    logic [FNUM_W-1:0]   fnum_reg, fnum_next;
    logic [BYTE_W-1:0]   hdr_hi_reg, hdr_hi_next;
    logic [BYTE_W-1:0]   hdr_lo_reg, hdr_lo_next;

    logic                accept;
    logic                advance;
    logic                no_frame;
    logic                at_cap;
    logic                do_close;
    logic [FB_W-1:0]     frames_inc;
    logic [HDR_W-1:0]    count_ext;
    logic [WCOUNT_W-1:0] words_inc;
    logic [OFFSET_W-1:0] pay_off;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_EMIT);
    assign advance   = res_valid && res_ready;

    assign no_frame   = (words_reg == '0);
    assign at_cap     = (frames_reg >= FB_W'(MAX_FRAMES));
    assign frames_inc = no_frame ? frames_reg + FB_W'(1) : frames_reg;
    assign count_ext  = HDR_W'(frames_inc);
    assign words_inc  = words_reg + WCOUNT_W'(1);
    assign do_close   = (words_inc >= WCOUNT_W'(CAP)) || in_last;
    // payload high byte sits after the 2-byte header
    assign pay_off    = OFFSET_W'(2) + {words_reg, 1'b0};

    always_comb begin
        state_next   = state_reg;
        frames_next  = frames_reg;
        words_next   = words_reg;
        word_next    = word_reg;
        off_next     = off_reg;
        end_off_next = end_off_reg;
        pay_off_next = pay_off_reg;
        fnum_next    = fnum_reg;
        hdr_hi_next  = hdr_hi_reg;
        hdr_lo_next  = hdr_lo_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (no_frame && at_cap) begin
                        // capacity used up: word dropped
                        if (in_last) begin
                            frames_next = '0;
                            words_next  = '0;
                        end
                    end else begin
                        state_next   = ST_EMIT;
                        word_next    = in_word;
                        pay_off_next = pay_off;
                        off_next     = no_frame ? '0 : pay_off;
                        end_off_next = do_close ? LAST_OFFSET : pay_off + OFFSET_W'(1);
                        fnum_next    = count_ext[FNUM_W-1:0];
                        hdr_hi_next  = count_ext[2*BYTE_W-1:BYTE_W];
                        hdr_lo_next  = count_ext[BYTE_W-1:0];
                        frames_next  = in_last ? '0 : frames_inc;
                        words_next   = do_close ? '0 : words_inc;
                    end
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    if (off_reg == end_off_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        off_next = off_reg + OFFSET_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (off_reg == '0) begin
            res.frame_byte = hdr_hi_reg;
        end else if (off_reg == OFFSET_W'(1)) begin
            res.frame_byte = hdr_lo_reg;
        end else if (off_reg == pay_off_reg) begin
            res.frame_byte = word_reg[WORD_W-1:BYTE_W];
        end else if (off_reg == pay_off_reg + OFFSET_W'(1)) begin
            res.frame_byte = word_reg[BYTE_W-1:0];
        end else begin
            res.frame_byte = '0;
        end
        res.frame_number = fnum_reg;
        res.byte_offset  = off_reg;
        res.frame_end    = (off_reg == LAST_OFFSET);
        res.run_end      = (off_reg == end_off_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            frames_reg <= '0;
            words_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            frames_reg <= frames_next;
            words_reg  <= words_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        off_reg     <= off_next;
        end_off_reg <= end_off_next;
        pay_off_reg <= pay_off_next;
        fnum_reg    <= fnum_next;
        hdr_hi_reg  <= hdr_hi_next;
        hdr_lo_reg  <= hdr_lo_next;
    end

endmodule
`default_nettype wire

/* rtl/wsfd_out.sv */
`default_nettype none
module wsfd_out (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            res_valid,
    output logic                           res_ready,
    input  wsfd_pkg::wsfd_result_t         res,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [wsfd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import wsfd_pkg::*;

    logic         valid_reg, valid_next;
    wsfd_result_t data_reg, data_next;
    logic         load;

    assign res_ready = !valid_reg || m_tready;
    assign load      = res_valid && res_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {M_TDATA_W'(0)} |
                      M_TDATA_W'({data_reg.byte_offset, data_reg.frame_number,
                                  data_reg.frame_byte});
    assign m_tlast  = data_reg.frame_end;
    assign m_tuser  = data_reg.run_end;

endmodule
`default_nettype wire

/* rtl/word_stream_can_fd_framer_top.sv */
// word stream to can-fd frame packer
// slave side: one 16-bit message word per transaction on s_tdata, s_tlast marks
//   the final word of the message
// master side: one frame byte per transaction; tdata carries byte, frame number
//   and byte offset, m_tlast flags offset 63, m_tuser flags the last byte caused
//   by the input word
// a frame opens with a 2-byte big-endian frame number (from 1), then up to
//   WORDS_PER_FRAME words (at most 31) high byte first; a full frame or the message
//   end is zero filled to 64 bytes; beyond MAX_FRAMES frames words are dropped
// timing: an input word produces 2 to 64 bytes, one per cycle while m_tready
//   does not stall, from a single offset counter and byte selector; the accept
//   cycle itself yields no byte, and a dropped word is taken and yields none
// each byte is registered in the sequencer and again in the output register
// s_tready is low while a word's bytes are being produced
// a stall on m_tready holds the output register and freezes the byte counter
// reset (aresetn low, synchronous) empties the output register and clears the
//   frame and word counts
`default_nettype none
module word_stream_can_fd_framer_top #(
    parameter int MAX_FRAMES      = 16,
    parameter int WORDS_PER_FRAME = 31
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [wsfd_pkg::WORD_W-1:0]    s_tdata,  // [15:0] data_word
    input  wire                            s_tlast,  // last_word
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [wsfd_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] frame_byte,
                                                     // [12:8] frame_number,
                                                     // [18:13] byte_offset, rest zero
    output logic                           m_tlast,  // frame_end
    output logic                           m_tuser   // run_end
);
    import wsfd_pkg::*;

    // sequencer to output register
    logic         res_valid;
    logic         res_ready;
    wsfd_result_t res;

    wsfd_seq #(
        .MAX_FRAMES      (MAX_FRAMES),
        .WORDS_PER_FRAME (WORDS_PER_FRAME)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register decouples the byte counter from the receiver
    wsfd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

/* rtl/wsfd_checker.sv */
`default_nettype none
module wsfd_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [wsfd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                            m_tlast,
    input wire                            m_tuser
);
    import wsfd_pkg::*;

    logic [OFFSET_W-1:0] offset;
    assign offset = m_tdata[OFFSET_LSB +: OFFSET_W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // frame end flag only on the final byte slot
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (offset == LAST_OFFSET)))
        else $error("frame end flag out of place");

    // input stays blocked while the output holds a byte that is not the word's last
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !s_tready)
        else $error("input taken while bytes outstanding");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind word_stream_can_fd_framer_top wsfd_checker u_wsfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
